// ===== rtl/cda_pkg.sv =====
package cda_pkg;

  // Operation codes carried in the func field of an input item.
  typedef enum logic [1:0] {
    OP_SET        = 2'd0,
    OP_ADD_DAYS   = 2'd1,
    OP_ADD_MONTHS = 2'd2,
    OP_ADD_YEARS  = 2'd3
  } op_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEAP_MUL,
    ST_LEAP_CHK,
    ST_SET_CHK,
    ST_DAY_STEP,
    ST_MON_MUL,
    ST_MON_APPLY,
    ST_CLAMP,
    ST_DONE
  } state_t;

  localparam int YEAR_W  = 16;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int AMT_W   = 16;

  localparam int MUL_W  = 15;
  localparam int PROD_W = 2 * MUL_W;

  // Reciprocal constants: x / 25 = (x * DIV25_K) >> DIV25_SHIFT for x below 2**14,
  // and x / 3 = (x * DIV3_K) >> DIV3_SHIFT for x below 2**15.
  localparam logic [MUL_W-1:0] DIV25_K   = 15'd20972;
  localparam int               DIV25_SHIFT = 19;
  localparam logic [MUL_W-1:0] DIV3_K    = 15'd21846;
  localparam int               DIV3_SHIFT  = 16;

  localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
  localparam logic [MONTH_W-1:0] FEBRUARY        = 4'd2;

  // Length of a month; a month code outside 1 to 12 gets 31 days.
  function automatic logic [DAY_W-1:0] days_in(input logic leap,
                                                input logic [MONTH_W-1:0] month);
    logic [DAY_W-1:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      FEBRUARY:                                   len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/cda_leap.sv =====
// Gregorian leap test. The caller supplies the year and the registered
// quotient of (year >> 2) / 25, which equals year / 100 whenever the year is
// a multiple of four.
module cda_leap (
  input  logic [cda_pkg::YEAR_W-1:0] year,
  input  logic [10:0]                q25,
  output logic                       leap
);

  logic [cda_pkg::YEAR_W-1:0] m25;
  logic                       div4;
  logic                       div100;

  assign m25    = ({5'd0, q25} << 4) + ({5'd0, q25} << 3) + {5'd0, q25};
  assign div4   = (year[1:0] == 2'b00);
  assign div100 = div4 && (m25 == {2'b00, year[cda_pkg::YEAR_W-1:2]});
  // A multiple of 100 is a leap year only when year / 100 is a multiple of four.
  assign leap   = div100 ? (q25[1:0] == 2'b00) : div4;

endmodule

// ===== rtl/calendar_date_adder.sv =====
// Calendar date adder. The block holds one Gregorian date (year, month, day),
// starting at year 0, January 1 after reset. Each item either loads a date
// (func 0) or adds amount days (1), months (2) or years (3) to the held date,
// and every item returns exactly one result item with the date that follows.
// A load with a month outside 1 to 12 or a day that is 0 or past the end of
// that month is ignored and returns the unchanged date with rejected set.
// Month and year adds clamp the day to the last day of the target month, and
// the year wraps modulo 65536. Items are handled one at a time by a small
// sequencer around one shared 15 by 15 bit multiplier (used for the divide by
// 100 of the leap test and the divide by 12 of month adds); req_stall stays
// high from acceptance until the result item has been taken. A load runs the
// leap multiply, leap check and set check states, a year add the leap multiply,
// leap check and clamp states, and a month add the month multiply, month apply,
// leap multiply, leap check and clamp states before the result. A day add walks
// one month per cycle and pauses for the leap test each time it crosses into a
// new year.
module calendar_date_adder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    func,
  input  logic [cda_pkg::YEAR_W-1:0]    new_year,
  input  logic [cda_pkg::MONTH_W-1:0]   new_month,
  input  logic [cda_pkg::DAY_W-1:0]     new_day,
  input  logic [cda_pkg::AMT_W-1:0]     amount,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [cda_pkg::YEAR_W-1:0]    cur_year,
  output logic [cda_pkg::MONTH_W-1:0]   cur_month,
  output logic [cda_pkg::DAY_W-1:0]     cur_day,
  output logic                          rejected
);

  cda_pkg::state_t state, state_next;

  // Held date.
  logic [cda_pkg::YEAR_W-1:0]  year;
  logic [cda_pkg::MONTH_W-1:0] month;
  logic [cda_pkg::DAY_W-1:0]   day;

  // Captured item.
  cda_pkg::op_t                op;
  logic [cda_pkg::YEAR_W-1:0]  ny;
  logic [cda_pkg::MONTH_W-1:0] nm;
  logic [cda_pkg::DAY_W-1:0]   nd;
  logic [cda_pkg::AMT_W-1:0]   left;

  logic                        leap;
  logic                        rej;
  logic [cda_pkg::PROD_W-1:0]  prod;

  logic                        accept;
  logic [cda_pkg::YEAR_W-1:0]  test_year;
  logic                        leap_now;
  logic [cda_pkg::MUL_W-1:0]   mul_a;
  logic [cda_pkg::MUL_W-1:0]   mul_k;
  logic [16:0]                 total;
  logic [13:0]                 qm;
  logic [16:0]                 q12;
  logic [16:0]                 rem;
  logic [16:0]                 day_sum;
  logic [cda_pkg::DAY_W-1:0]   last;
  logic [cda_pkg::DAY_W-1:0]   set_last;
  logic [cda_pkg::DAY_W-1:0]   step;
  logic                        set_ok;

  assign accept    = req_valid && !req_stall;

  // The leap test looks at the requested year for a load and at the held
  // year for every add.
  assign test_year = (op == cda_pkg::OP_SET) ? ny : year;

  // Shared multiplier operands: divide by 25 for the leap test, by 3 for
  // month adds (both after a shift right by two).
  assign total = 17'(month) - 17'd1 + 17'(left);
  always_comb begin
    if (state == cda_pkg::ST_LEAP_MUL) begin
      mul_a = {1'b0, test_year[cda_pkg::YEAR_W-1:2]};
      mul_k = cda_pkg::DIV25_K;
    end else begin
      mul_a = total[16:2];
      mul_k = cda_pkg::DIV3_K;
    end
  end

  cda_leap u_leap (
    .year (test_year),
    .q25  (prod[cda_pkg::PROD_W-1:cda_pkg::DIV25_SHIFT]),
    .leap (leap_now)
  );

  // Month add: quotient by 12 and remainder.
  assign qm  = prod[cda_pkg::PROD_W-1:cda_pkg::DIV3_SHIFT];
  assign q12 = 17'({qm, 3'b000}) + 17'({qm, 2'b00});
  assign rem = total - q12;

  // Day walk: one month per step.
  assign last    = cda_pkg::days_in(leap, month);
  assign day_sum = 17'(left) + 17'(day);
  assign step    = last - day + 5'd1;

  assign set_last = cda_pkg::days_in(leap, nm);
  assign set_ok   = (nm >= 4'd1) && (nm <= cda_pkg::MONTHS_PER_YEAR) &&
                    (nd != '0) && (nd <= set_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cda_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    rsp_valid  = 1'b0;
    unique case (state)
      cda_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          if (cda_pkg::op_t'(func) == cda_pkg::OP_ADD_MONTHS) begin
            state_next = cda_pkg::ST_MON_MUL;
          end else begin
            state_next = cda_pkg::ST_LEAP_MUL;
          end
        end
      end
      cda_pkg::ST_LEAP_MUL: state_next = cda_pkg::ST_LEAP_CHK;
      cda_pkg::ST_LEAP_CHK: begin
        unique case (op)
          cda_pkg::OP_SET:      state_next = cda_pkg::ST_SET_CHK;
          cda_pkg::OP_ADD_DAYS: state_next = cda_pkg::ST_DAY_STEP;
          default:              state_next = cda_pkg::ST_CLAMP;
        endcase
      end
      cda_pkg::ST_SET_CHK:   state_next = cda_pkg::ST_DONE;
      cda_pkg::ST_DAY_STEP: begin
        if (day_sum <= 17'(last)) begin
          state_next = cda_pkg::ST_DONE;
        end else if (month >= cda_pkg::MONTHS_PER_YEAR) begin
          state_next = cda_pkg::ST_LEAP_MUL;
        end
      end
      cda_pkg::ST_MON_MUL:   state_next = cda_pkg::ST_MON_APPLY;
      cda_pkg::ST_MON_APPLY: state_next = cda_pkg::ST_LEAP_MUL;
      cda_pkg::ST_CLAMP:     state_next = cda_pkg::ST_DONE;
      cda_pkg::ST_DONE: begin
        rsp_valid = 1'b1;
        if (!rsp_stall) begin
          state_next = cda_pkg::ST_IDLE;
        end
      end
      default: state_next = cda_pkg::ST_IDLE;
    endcase
  end

  // Date registers reset to year 0, January 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      year  <= '0;
      month <= 4'd1;
      day   <= 5'd1;
      rej   <= 1'b0;
    end else begin
      unique case (state)
        cda_pkg::ST_IDLE: begin
          if (accept) begin
            rej <= 1'b0;
            if (cda_pkg::op_t'(func) == cda_pkg::OP_ADD_YEARS) begin
              year <= year + amount;
            end
          end
        end
        cda_pkg::ST_SET_CHK: begin
          if (set_ok) begin
            year  <= ny;
            month <= nm;
            day   <= nd;
          end else begin
            rej <= 1'b1;
          end
        end
        cda_pkg::ST_DAY_STEP: begin
          if (day_sum <= 17'(last)) begin
            day <= day_sum[cda_pkg::DAY_W-1:0];
          end else begin
            day <= 5'd1;
            if (month >= cda_pkg::MONTHS_PER_YEAR) begin
              month <= 4'd1;
              year  <= year + 16'd1;
            end else begin
              month <= month + 4'd1;
            end
          end
        end
        cda_pkg::ST_MON_APPLY: begin
          year  <= year + {2'b00, qm};
          month <= rem[cda_pkg::MONTH_W-1:0] + 4'd1;
        end
        cda_pkg::ST_CLAMP: begin
          if (day > last) begin
            day <= last;
          end
        end
        default: ;
      endcase
    end
  end

  // Item capture, walk counter, multiplier and leap flag.
  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= cda_pkg::op_t'(func);
      ny   <= new_year;
      nm   <= new_month;
      nd   <= new_day;
      left <= amount;
    end else if (state == cda_pkg::ST_DAY_STEP && day_sum > 17'(last)) begin
      left <= left - 16'(step);
    end
    if (state == cda_pkg::ST_LEAP_MUL || state == cda_pkg::ST_MON_MUL) begin
      prod <= mul_a * mul_k;
    end
    if (state == cda_pkg::ST_LEAP_CHK) begin
      leap <= leap_now;
    end
  end

  assign cur_year  = year;
  assign cur_month = month;
  assign cur_day   = day;
  assign rejected  = rej;

  // The result always shows a month in range and a nonzero day.
  a_month_day_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (month >= 4'd1) && (month <= cda_pkg::MONTHS_PER_YEAR) && (day != '0))
    else $error("result date has a month or day out of range");

  // Unless a load was rejected, the day never runs past the end of its month.
  a_day_in_month: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rej) |-> (day <= cda_pkg::days_in(leap, month)))
    else $error("result day exceeds the month length");

  // Only a load can be rejected.
  a_reject_only_set: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rej) |-> (op == cda_pkg::OP_SET))
    else $error("an add reported a rejected item");

  // Every item goes through a multiply state before its result, so no result appears right after acceptance.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> !rsp_valid)
    else $error("result appeared in the cycle after acceptance");

endmodule
